[hdl/tph_pkg.sv]
// types, constants and angle table for the two-point position and heading block
`timescale 1ns / 1ps
package tph_pkg;

   localparam int COORD_W   = 14;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int GUARD_W   = 8;
   localparam int VEC_W     = DELTA_W + GUARD_W + 3;
   localparam int ANGLE_W   = 20;
   localparam int HEADING_W = 16;
   localparam int ATAN_LEN  = 24;
   localparam int STAGE_IDX_W = 5;

   localparam logic signed [ANGLE_W-1:0]   PI_Q16 = 20'sd205887;
   localparam logic signed [HEADING_W-1:0] PI_Q13 = 16'sd25736;

   typedef struct packed {
      logic [COORD_W-1:0]      pos_x;
      logic [COORD_W-1:0]      pos_y;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANGLE_W-1:0] z;
      logic                    degenerate;
      logic                    left;
   } cordic_word_type;

   typedef struct packed {
      logic [COORD_W-1:0]          pos_x;
      logic [COORD_W-1:0]          pos_y;
      logic signed [HEADING_W-1:0] heading;
      logic                        degenerate;
   } result_word_type;

   // atan(2^-i) in Q16
   function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [STAGE_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:  val = 20'sd51472;
         5'd1:  val = 20'sd30386;
         5'd2:  val = 20'sd16055;
         5'd3:  val = 20'sd8150;
         5'd4:  val = 20'sd4091;
         5'd5:  val = 20'sd2047;
         5'd6:  val = 20'sd1024;
         5'd7:  val = 20'sd512;
         5'd8:  val = 20'sd256;
         5'd9:  val = 20'sd128;
         5'd10: val = 20'sd64;
         5'd11: val = 20'sd32;
         5'd12: val = 20'sd16;
         5'd13: val = 20'sd8;
         5'd14: val = 20'sd4;
         5'd15: val = 20'sd2;
         5'd16: val = 20'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[hdl/tph_if.sv]
// valid/ready channel interfaces for point pairs and results
`timescale 1ns / 1ps
interface tph_req_if
   import tph_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] first_x;
   logic [COORD_W-1:0] first_y;
   logic [COORD_W-1:0] second_x;
   logic [COORD_W-1:0] second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface tph_rsp_if
   import tph_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic [COORD_W-1:0]          pos_x;
   logic [COORD_W-1:0]          pos_y;
   logic signed [HEADING_W-1:0] heading;
   logic                        degenerate;

   modport source (output valid, pos_x, pos_y, heading, degenerate, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, degenerate, output ready);
endinterface

[hdl/tph_pre.sv]
// input stage: point differences, guard scaling and half-plane prerotation
`timescale 1ns / 1ps
module tph_pre
   import tph_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] first_x,
   input  logic [COORD_W-1:0] first_y,
   input  logic [COORD_W-1:0] second_x,
   input  logic [COORD_W-1:0] second_y,
   output logic               out_valid,
   output cordic_word_type    out_word
);

   logic                     valid_ff;
   cordic_word_type          word_ff;
   cordic_word_type          word_in;
   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic signed [VEC_W-1:0]  sx;
   logic signed [VEC_W-1:0]  sy;

   always_comb begin
      dx = $signed({1'b0, second_x}) - $signed({1'b0, first_x});
      dy = $signed({1'b0, second_y}) - $signed({1'b0, first_y});
      sx = VEC_W'(dx) <<< GUARD_W;
      sy = VEC_W'(dy) <<< GUARD_W;
      word_in.pos_x      = first_x;
      word_in.pos_y      = first_y;
      word_in.degenerate = (dx == '0) && (dy == '0);
      word_in.left       = (dy == '0) && dx[DELTA_W-1];
      if (dx[DELTA_W-1]) begin
         word_in.x = -sx;
         word_in.y = -sy;
         word_in.z = dy[DELTA_W-1] ? -PI_Q16 : PI_Q16;
      end else begin
         word_in.x = sx;
         word_in.y = sy;
         word_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[hdl/tph_cordic_stage.sv]
// one registered cordic vectoring micro-rotation
`timescale 1ns / 1ps
module tph_cordic_stage
   import tph_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  cordic_word_type in_word,
   output logic            out_valid,
   output cordic_word_type out_word
);

   localparam logic signed [ANGLE_W-1:0] ATAN_STEP = atan_q16(STAGE_IDX_W'(STAGE));

   logic                    valid_ff;
   cordic_word_type         word_ff;
   cordic_word_type         word_in;
   logic signed [VEC_W-1:0] xs;
   logic signed [VEC_W-1:0] ys;

   always_comb begin
      xs      = in_word.x >>> STAGE;
      ys      = in_word.y >>> STAGE;
      word_in = in_word;
      if (!in_word.y[VEC_W-1]) begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + ATAN_STEP;
      end else begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[hdl/tph_post.sv]
// output stage: rounding to q13, negation, clamping and special headings
`timescale 1ns / 1ps
module tph_post
   import tph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  cordic_word_type in_word,
   output logic            out_valid,
   output result_word_type out_word
);

   logic                      valid_ff;
   result_word_type           word_ff;
   result_word_type           word_in;
   logic signed [ANGLE_W-1:0] rounded;
   logic signed [ANGLE_W:0]   negated;

   always_comb begin
      rounded = (in_word.z + ANGLE_W'(4)) >>> 3;
      negated = -(ANGLE_W+1)'(rounded);
      word_in.pos_x      = in_word.pos_x;
      word_in.pos_y      = in_word.pos_y;
      word_in.degenerate = in_word.degenerate;
      priority if (in_word.degenerate) begin
         word_in.heading = '0;
      end else if (in_word.left) begin
         word_in.heading = PI_Q13;
      end else if (negated > (ANGLE_W+1)'(PI_Q13)) begin
         word_in.heading = PI_Q13;
      end else if (negated < -(ANGLE_W+1)'(PI_Q13)) begin
         word_in.heading = -PI_Q13;
      end else begin
         word_in.heading = HEADING_W'(negated);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[hdl/two_point_position_heading.sv]
// top level: position passthrough and pipelined cordic heading from two points
//
//   channel  dir  words carried
//   req      in   first_x, first_y, second_x, second_y
//   rsp      out  pos_x, pos_y, heading, degenerate
//
// the pipeline is an input stage, one stage per rotation and an output stage;
// one word per cycle is accepted and delivered while rsp is not stalled.
// every stage holds a valid bit and loads when empty or when the next one moves,
// so bubbles collapse and a stall on rsp backs up without loss.
// synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
module two_point_position_heading
   import tph_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input logic      clock,
   input logic      reset,
   tph_req_if.sink  req,
   tph_rsp_if.source rsp
);

   localparam int DEPTH = CORDIC_STAGES + 2;

   logic [DEPTH-1:0]  valid;
   logic [DEPTH-1:0]  advance;
   cordic_word_type   word [DEPTH-1];
   result_word_type   result;

   always_comb begin
      advance[DEPTH-1] = !valid[DEPTH-1] || rsp.ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         advance[k] = !valid[k] || advance[k+1];
      end
   end

   assign req.ready = advance[0];

   tph_pre u_pre (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance[0]),
      .in_valid (req.valid),
      .first_x  (req.first_x),
      .first_y  (req.first_y),
      .second_x (req.second_x),
      .second_y (req.second_y),
      .out_valid(valid[0]),
      .out_word (word[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      tph_cordic_stage #(
         .STAGE(i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance[i+1]),
         .in_valid (valid[i]),
         .in_word  (word[i]),
         .out_valid(valid[i+1]),
         .out_word (word[i+1])
      );
   end

   tph_post u_post (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance[DEPTH-1]),
      .in_valid (valid[DEPTH-2]),
      .in_word  (word[DEPTH-2]),
      .out_valid(valid[DEPTH-1]),
      .out_word (result)
   );

   assign rsp.valid      = valid[DEPTH-1];
   assign rsp.pos_x      = result.pos_x;
   assign rsp.pos_y      = result.pos_y;
   assign rsp.heading    = result.heading;
   assign rsp.degenerate = result.degenerate;

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |-> rsp.heading == '0)
      else $error("degenerate word with nonzero heading");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.heading <= PI_Q13) && (rsp.heading >= -PI_Q13))
      else $error("heading outside plus or minus pi");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid && req.ready)
      else $error("pipeline not empty after reset");

endmodule
